// ----- rtl/bitmap_zone_allocator_assert.svh -----
// Assertion macros for the bitmap zone allocator.
// Expects i_clk and i_rst_n in the including module; no other dependencies.
`ifndef BITMAP_ZONE_ALLOCATOR_ASSERT_SVH
`define BITMAP_ZONE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BZA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BZA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bza_pkg.sv -----
// Package for the bitmap zone allocator: sizes, codes and state type.
// No dependencies.
`default_nettype none

package bza_pkg;

    localparam int MAP_BLOCK_BITS = 1024;
    localparam int MAP_BLOCKS     = 4;
    localparam int WORD_BITS      = 64;

    localparam int TOTAL_BITS = MAP_BLOCKS * MAP_BLOCK_BITS;
    localparam int MAP_WORDS  = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = $clog2(WORD_BITS);
    localparam int MAP_AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PTR_W      = $clog2(MAP_WORDS + 1);
    localparam int BIT_W      = $clog2(TOTAL_BITS + 1);
    localparam int POP_W      = $clog2(WORD_BITS + 1);

    // Field widths fixed by the interface.
    localparam int ZONE_W = 16;
    localparam int RUN_W  = 13;
    localparam int CNT_W  = 13;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;
    localparam int MBU_W  = 3;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Wide arithmetic for zone and bit-address sums.
    localparam int LW = (BIT_W > ZONE_W + 2) ? BIT_W : ZONE_W + 2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_FIN
    } t_state;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_COUNT = 2'd2
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_NONE_FREE = 2'd2,
        ST_NO_BLOCK  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_FIRST_DATA_ZONE = 2'd0,
        REG_ZONE_COUNT      = 2'd1,
        REG_MAP_BLOCKS      = 2'd2
    } t_reg_idx;

endpackage

`default_nettype wire

// ----- rtl/bitmap_zone_allocator.sv -----
// Bitmap zone allocator: first-fit allocate, run free and free count over a zone bitmap.
// Depends on bza_pkg and bitmap_zone_allocator_assert.svh.
// Flow: an item goes PREP, SCAN (reading bitmap words), FIN (waits for the result register),
// then IDLE, where the next item is taken; range errors, func 3 and empty scans skip SCAN.
// Allocate reads up to the first clear bit, free the words of its run, count 16 words per block.
// Reset (synchronous, active low): map all used, free counter 0, registers to defaults.
`default_nettype none

`include "bitmap_zone_allocator_assert.svh"

module bitmap_zone_allocator (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // request channel
    input  wire                               i_valid,
    output logic                              o_ready,
    input  wire  [bza_pkg::FUNC_W-1:0]        i_func,
    input  wire  [bza_pkg::ZONE_W-1:0]        i_first_zone,
    input  wire  [bza_pkg::RUN_W-1:0]         i_run_length,
    // result channel
    output logic                              o_valid,
    input  wire                               i_ready,
    output logic [bza_pkg::ZONE_W-1:0]        o_zone_out,
    output logic [bza_pkg::STAT_W-1:0]        o_status,
    output logic [bza_pkg::CNT_W-1:0]         o_free_total,
    output logic [bza_pkg::CNT_W-1:0]         o_already_clear,
    // configuration port
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [bza_pkg::ADDR_W-1:0]        paddr,
    input  wire  [bza_pkg::DATA_W-1:0]        pwdata,
    output logic [bza_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    localparam int WB = bza_pkg::WORD_BITS;
    localparam int WA = bza_pkg::WORD_AW;
    localparam int LW = bza_pkg::LW;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    bza_pkg::t_state                 r_state, n_state;
    logic [bza_pkg::FUNC_W-1:0]      r_func;
    logic [bza_pkg::ZONE_W-1:0]      r_zone;
    logic [bza_pkg::RUN_W-1:0]       r_run;

    logic [bza_pkg::ZONE_W-1:0]      r_fdz;
    logic [bza_pkg::ZONE_W-1:0]      r_zc;
    logic [bza_pkg::MBU_W-1:0]       r_mbu;

    logic [bza_pkg::CNT_W-1:0]       r_free_ctr, n_free_ctr;
    logic [bza_pkg::CNT_W-1:0]       r_acc, n_acc;
    logic [bza_pkg::ZONE_W-1:0]      r_res_zone, n_res_zone;
    logic [bza_pkg::STAT_W-1:0]      r_res_status, n_res_status;

    logic [bza_pkg::PTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [bza_pkg::PTR_W-1:0]       r_end_word, n_end_word;
    logic [bza_pkg::BIT_W-1:0]       r_lo, n_lo;
    logic [bza_pkg::BIT_W-1:0]       r_hi, n_hi;

    logic                            r_dv;
    logic [bza_pkg::MAP_AW-1:0]      r_daddr;
    logic [WB-1:0]                   r_mem_q;
    logic                            r_q_vld;

    // Word store: an entry never written reads as all used.
    logic [WB-1:0]                   r_map_mem [bza_pkg::MAP_WORDS];
    logic [bza_pkg::MAP_WORDS-1:0]   r_map_vld;

    logic                            r_out_vld, n_out_vld;
    logic [bza_pkg::ZONE_W-1:0]      r_out_zone, n_out_zone;
    logic [bza_pkg::STAT_W-1:0]      r_out_status, n_out_status;
    logic [bza_pkg::CNT_W-1:0]       r_out_total, n_out_total;
    logic [bza_pkg::CNT_W-1:0]       r_out_clear, n_out_clear;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic       w_cfg_we;
    logic [1:0] w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_we  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[bza_pkg::ADDR_W-1:2];

    always_comb begin
        case (w_cfg_idx)
            bza_pkg::REG_FIRST_DATA_ZONE: prdata = bza_pkg::DATA_W'(r_fdz);
            bza_pkg::REG_ZONE_COUNT:      prdata = bza_pkg::DATA_W'(r_zc);
            bza_pkg::REG_MAP_BLOCKS:      prdata = bza_pkg::DATA_W'(r_mbu);
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fdz <= '0;
            r_zc  <= '0;
            r_mbu <= bza_pkg::MBU_W'(1);
        end else if (w_cfg_we) begin
            case (w_cfg_idx)
                bza_pkg::REG_FIRST_DATA_ZONE: r_fdz <= pwdata[bza_pkg::ZONE_W-1:0];
                bza_pkg::REG_ZONE_COUNT:      r_zc  <= pwdata[bza_pkg::ZONE_W-1:0];
                bza_pkg::REG_MAP_BLOCKS:      r_mbu <= pwdata[bza_pkg::MBU_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request setup: bit ranges per operation, worked out in the PREP cycle
    // ------------------------------------------------------------------
    logic [LW-1:0] w_nb_bits;   // bits in the map blocks in use
    logic [LW-1:0] w_span;      // zone_count - first_data_zone, floored at 0
    logic [LW-1:0] w_lim;       // allocate search limit
    logic [LW-1:0] w_sum;       // first_zone + run_length
    logic [LW-1:0] w_idx;       // map bit of first_zone
    logic [LW-1:0] w_end;       // one past the last map bit of the run
    logic [LW-1:0] w_stop;      // run end clipped to the blocks in use
    logic          w_rng_bad;
    logic          w_blk_bad;
    logic          w_tail_bad;

    assign w_nb_bits = (LW'(r_mbu) > LW'(bza_pkg::MAP_BLOCKS))
                     ? LW'(bza_pkg::TOTAL_BITS)
                     : LW'(r_mbu) * LW'(bza_pkg::MAP_BLOCK_BITS);
    assign w_span    = (r_zc > r_fdz) ? (LW'(r_zc) - LW'(r_fdz)) : '0;
    assign w_lim     = (w_span > LW'(bza_pkg::TOTAL_BITS)) ? LW'(bza_pkg::TOTAL_BITS) : w_span;
    assign w_sum     = LW'(r_zone) + LW'(r_run);
    assign w_rng_bad = (r_zone < r_fdz) || (w_sum >= LW'(r_zc));
    assign w_idx     = LW'(r_zone) - LW'(r_fdz) + LW'(1);
    assign w_end     = w_idx + LW'(r_run);
    assign w_blk_bad = (w_idx >= w_nb_bits);
    assign w_tail_bad = (w_end > w_nb_bits);
    assign w_stop    = w_tail_bad ? w_nb_bits : w_end;

    logic [bza_pkg::BIT_W-1:0]  v_lo, v_hi;
    logic [bza_pkg::STAT_W-1:0] v_status;
    logic                       w_do_scan;

    always_comb begin
        v_lo      = '0;
        v_hi      = '0;
        v_status  = bza_pkg::ST_RANGE;
        w_do_scan = 1'b0;
        case (r_func)
            bza_pkg::FUNC_ALLOC: begin
                v_hi      = bza_pkg::BIT_W'(w_lim);
                v_status  = bza_pkg::ST_NONE_FREE;
                w_do_scan = (w_lim != '0);
            end
            bza_pkg::FUNC_FREE: begin
                v_lo = bza_pkg::BIT_W'(w_idx);
                v_hi = bza_pkg::BIT_W'(w_stop);
                if (w_rng_bad) begin
                    v_status = bza_pkg::ST_RANGE;
                end else if (w_blk_bad || w_tail_bad) begin
                    v_status = bza_pkg::ST_NO_BLOCK;
                end else begin
                    v_status = bza_pkg::ST_OK;
                end
                w_do_scan = !w_rng_bad && !w_blk_bad && (w_stop > w_idx);
            end
            bza_pkg::FUNC_COUNT: begin
                v_hi      = bza_pkg::BIT_W'(w_nb_bits);
                v_status  = bza_pkg::ST_OK;
                w_do_scan = (w_nb_bits != '0);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared word unit: mask one word to [lo, hi), count its clear bits,
    // find its first clear bit
    // ------------------------------------------------------------------
    function automatic logic [WA-1:0] f_first_set(input logic [WB-1:0] v);
        logic [WA-1:0] pos;
        pos = '0;
        for (int k = WB - 1; k >= 0; k--) begin
            if (v[k]) begin
                pos = WA'(k);
            end
        end
        return pos;
    endfunction

    logic [WB-1:0]               w_word;
    logic                        w_lo_here, w_hi_here;
    logic [WA-1:0]               w_lo_off, w_hi_off;
    logic [WB-1:0]               w_mask;
    logic [bza_pkg::POP_W-1:0]   w_width;
    logic [WB-1:0]               w_zmask;
    logic [bza_pkg::POP_W-1:0]   w_zeros;
    logic [bza_pkg::POP_W-1:0]   w_ones;
    logic [WA-1:0]               w_first;
    logic                        w_found;
    logic                        w_last;
    logic [bza_pkg::BIT_W-1:0]   w_bit;

    assign w_word    = r_q_vld ? r_mem_q : '1;
    assign w_lo_here = ((r_lo >> WA) == bza_pkg::BIT_W'(r_daddr));
    assign w_hi_here = ((r_hi >> WA) == bza_pkg::BIT_W'(r_daddr));
    assign w_lo_off  = w_lo_here ? r_lo[WA-1:0] : '0;
    assign w_hi_off  = r_hi[WA-1:0];
    assign w_mask    = ({WB{1'b1}} << w_lo_off)
                     & (w_hi_here ? ~({WB{1'b1}} << w_hi_off) : {WB{1'b1}});
    assign w_width   = (w_hi_here ? bza_pkg::POP_W'(w_hi_off) : bza_pkg::POP_W'(WB))
                     - bza_pkg::POP_W'(w_lo_off);
    assign w_zmask   = ~w_word & w_mask;
    assign w_zeros   = bza_pkg::POP_W'($countones(w_zmask));
    assign w_ones    = w_width - w_zeros;
    assign w_first   = f_first_set(w_zmask);
    assign w_found   = |w_zmask;
    assign w_last    = ((bza_pkg::PTR_W'(r_daddr) + bza_pkg::PTR_W'(1)) == r_end_word);
    assign w_bit     = (bza_pkg::BIT_W'(r_daddr) << WA) | bza_pkg::BIT_W'(w_first);

    // Word write-back and scan control
    logic          w_eval;
    logic          w_finish;
    logic          w_mem_we;
    logic [WB-1:0] w_wdata;
    logic          w_issue;
    logic          w_out_free;

    assign w_eval = (r_state == bza_pkg::S_SCAN) && r_dv;

    always_comb begin
        w_finish = 1'b0;
        w_mem_we = 1'b0;
        w_wdata  = w_word;
        if (w_eval) begin
            case (r_func)
                bza_pkg::FUNC_ALLOC: begin
                    w_mem_we = w_found;
                    w_wdata  = w_word | (WB'(1) << w_first);
                    w_finish = w_found || w_last;
                end
                bza_pkg::FUNC_FREE: begin
                    w_mem_we = 1'b1;
                    w_wdata  = w_word & ~w_mask;
                    w_finish = w_last;
                end
                default: begin
                    w_finish = w_last;
                end
            endcase
        end
    end

    assign w_issue    = (r_state == bza_pkg::S_SCAN) && (r_rd_ptr < r_end_word) && !w_finish;
    assign w_out_free = !r_out_vld || i_ready;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            bza_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = bza_pkg::S_PREP;
                end
            end
            bza_pkg::S_PREP: begin
                n_state = w_do_scan ? bza_pkg::S_SCAN : bza_pkg::S_FIN;
            end
            bza_pkg::S_SCAN: begin
                if (w_finish) begin
                    n_state = bza_pkg::S_FIN;
                end
            end
            bza_pkg::S_FIN: begin
                if (w_out_free) begin
                    n_state = bza_pkg::S_IDLE;
                end
            end
            default: n_state = bza_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath and outputs
    // ------------------------------------------------------------------
    logic [bza_pkg::CNT_W:0] v_ctr_sum;
    logic [LW-1:0]           v_zone;

    always_comb begin
        n_free_ctr   = r_free_ctr;
        n_acc        = r_acc;
        n_res_zone   = r_res_zone;
        n_res_status = r_res_status;
        n_rd_ptr     = r_rd_ptr;
        n_end_word   = r_end_word;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_out_vld    = r_out_vld && !i_ready;
        n_out_zone   = r_out_zone;
        n_out_status = r_out_status;
        n_out_total  = r_out_total;
        n_out_clear  = r_out_clear;
        v_ctr_sum    = {1'b0, r_free_ctr} + (bza_pkg::CNT_W + 1)'(w_ones);
        v_zone       = LW'(w_bit) + LW'(r_fdz) - LW'(1);

        case (r_state)
            bza_pkg::S_PREP: begin
                n_lo         = v_lo;
                n_hi         = v_hi;
                n_rd_ptr     = bza_pkg::PTR_W'(v_lo >> WA);
                n_end_word   = bza_pkg::PTR_W'((LW'(v_hi) + LW'(WB - 1)) >> WA);
                n_res_status = v_status;
                n_res_zone   = '0;
                n_acc        = '0;
            end
            bza_pkg::S_SCAN: begin
                if (w_issue) begin
                    n_rd_ptr = r_rd_ptr + bza_pkg::PTR_W'(1);
                end
                if (w_eval) begin
                    case (r_func)
                        bza_pkg::FUNC_ALLOC: begin
                            if (w_found) begin
                                // Bit zero has no zone: keep it set and report range.
                                if (w_bit == '0) begin
                                    n_res_status = bza_pkg::ST_RANGE;
                                end else begin
                                    n_res_status = bza_pkg::ST_OK;
                                    n_res_zone   = v_zone[bza_pkg::ZONE_W-1:0];
                                    if (r_free_ctr != '0) begin
                                        n_free_ctr = r_free_ctr - bza_pkg::CNT_W'(1);
                                    end
                                end
                            end
                        end
                        bza_pkg::FUNC_FREE: begin
                            n_free_ctr = v_ctr_sum[bza_pkg::CNT_W]
                                       ? bza_pkg::CNT_MAX
                                       : v_ctr_sum[bza_pkg::CNT_W-1:0];
                            n_acc      = r_acc + bza_pkg::CNT_W'(w_zeros);
                        end
                        default: begin
                            n_acc = r_acc + bza_pkg::CNT_W'(w_zeros);
                        end
                    endcase
                end
            end
            bza_pkg::S_FIN: begin
                if (w_out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_zone   = r_res_zone;
                    n_out_status = r_res_status;
                    n_out_total  = (r_func == bza_pkg::FUNC_COUNT) ? r_acc : r_free_ctr;
                    n_out_clear  = (r_func == bza_pkg::FUNC_FREE) ? r_acc : '0;
                end
            end
            default: ;
        endcase
    end

    assign o_ready         = (r_state == bza_pkg::S_IDLE);
    assign o_valid         = r_out_vld;
    assign o_zone_out      = r_out_zone;
    assign o_status        = r_out_status;
    assign o_free_total    = r_out_total;
    assign o_already_clear = r_out_clear;

    // ------------------------------------------------------------------
    // Control and payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bza_pkg::S_IDLE;
            r_free_ctr <= '0;
            r_dv       <= 1'b0;
            r_out_vld  <= 1'b0;
            r_map_vld  <= '0;
        end else begin
            r_state    <= n_state;
            r_free_ctr <= n_free_ctr;
            r_dv       <= w_issue;
            r_out_vld  <= n_out_vld;
            if (w_mem_we) begin
                r_map_vld[r_daddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // Capture the request transaction.
        if (i_valid && o_ready) begin
            r_func <= i_func;
            r_zone <= i_first_zone;
            r_run  <= i_run_length;
        end
        r_acc        <= n_acc;
        r_res_zone   <= n_res_zone;
        r_res_status <= n_res_status;
        r_rd_ptr     <= n_rd_ptr;
        r_end_word   <= n_end_word;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_out_zone   <= n_out_zone;
        r_out_status <= n_out_status;
        r_out_total  <= n_out_total;
        r_out_clear  <= n_out_clear;
    end

    // Bitmap word memory: one read, one write per cycle, registered read data.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_map_mem[r_daddr] <= w_wdata;
        end
        if (w_issue) begin
            r_mem_q <= r_map_mem[r_rd_ptr[bza_pkg::MAP_AW-1:0]];
            r_q_vld <= r_map_vld[r_rd_ptr[bza_pkg::MAP_AW-1:0]];
            r_daddr <= r_rd_ptr[bza_pkg::MAP_AW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BZA_ASSERT_IMP(a_wr_in_scan, w_mem_we, (r_state == bza_pkg::S_SCAN) && r_dv, "map write outside scan")
    `BZA_ASSERT_IMP(a_alloc_one_bit, w_mem_we && (r_func == bza_pkg::FUNC_ALLOC), $countones(w_wdata) == ($countones(w_word) + 1), "allocate must set exactly one bit")
    `BZA_ASSERT_IMP(a_ptr_bound, r_state == bza_pkg::S_SCAN, r_rd_ptr <= r_end_word, "read pointer past scan end")
    `BZA_ASSERT_NXT(a_accept_prep, i_valid && o_ready, r_state == bza_pkg::S_PREP, "accepted transaction did not start")

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_zone_allocator: allocate, run free and free count.
// Depends on bza_pkg and the RTL; a built-in predictor checks every result transaction.

module tb_top;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LONG_HOLD    = 600;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [bza_pkg::FUNC_W-1:0] func;
        logic [bza_pkg::ZONE_W-1:0] first_zone;
        logic [bza_pkg::RUN_W-1:0]  run_length;
    } t_zone_op;

    typedef struct packed {
        logic [bza_pkg::ZONE_W-1:0] zone_out;
        logic [bza_pkg::STAT_W-1:0] status;
        logic [bza_pkg::CNT_W-1:0]  free_total;
        logic [bza_pkg::CNT_W-1:0]  already_clear;
    } t_zone_result;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Request channel
    logic                       i_valid      = 1'b0;
    logic                       o_ready;
    logic [bza_pkg::FUNC_W-1:0] i_func       = '0;
    logic [bza_pkg::ZONE_W-1:0] i_first_zone = '0;
    logic [bza_pkg::RUN_W-1:0]  i_run_length = '0;

    // Result channel
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [bza_pkg::ZONE_W-1:0] o_zone_out;
    logic [bza_pkg::STAT_W-1:0] o_status;
    logic [bza_pkg::CNT_W-1:0]  o_free_total;
    logic [bza_pkg::CNT_W-1:0]  o_already_clear;

    // Configuration port
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [bza_pkg::ADDR_W-1:0] paddr   = '0;
    logic [bza_pkg::DATA_W-1:0] pwdata  = '0;
    logic [bza_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    bitmap_zone_allocator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_first_zone    (i_first_zone),
        .i_run_length    (i_run_length),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_zone_out      (o_zone_out),
        .o_status        (o_status),
        .o_free_total    (o_free_total),
        .o_already_clear (o_already_clear),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // ------------------------------------------------------------------
    // Shadow state of the allocator, kept in step with every accepted
    // request transaction. The map resets to all used, the counter to 0.
    // ------------------------------------------------------------------
    logic [bza_pkg::TOTAL_BITS-1:0] used_map   = '1;
    logic [bza_pkg::CNT_W-1:0]      free_cnt   = '0;
    logic [bza_pkg::ZONE_W-1:0]     cfg_fdz    = '0;
    logic [bza_pkg::ZONE_W-1:0]     cfg_zones  = '0;
    logic [bza_pkg::MBU_W-1:0]      cfg_blocks = 3'd1;

    t_zone_op     zone_op_q[$];      // requests waiting to be offered
    t_zone_result zone_result_q[$];  // predicted results, oldest first

    int unsigned err_count     = 0;
    int unsigned cycle_count   = 0;
    bit          no_idle       = 1'b0;
    bit          long_hold_req = 1'b0;

    // Compute the result of one request and update the shadow map.
    function automatic t_zone_result apply_zone_op(input logic [bza_pkg::FUNC_W-1:0] func,
                                                   input logic [bza_pkg::ZONE_W-1:0] fz,
                                                   input logic [bza_pkg::RUN_W-1:0]  rl);
        t_zone_result r;
        int lim, b, idx, cnt, nb, blk, left, n, k, zone_i, clr, c;
        bit stop;
        r        = '0;
        r.status = bza_pkg::ST_OK;
        nb       = (cfg_blocks > bza_pkg::MAP_BLOCKS) ? bza_pkg::MAP_BLOCKS : cfg_blocks;
        case (func)
            bza_pkg::FUNC_ALLOC: begin
                // Search below zone_count - first_data_zone, capped by the map size.
                lim = (cfg_zones > cfg_fdz) ? cfg_zones - cfg_fdz : 0;
                if (lim > bza_pkg::TOTAL_BITS)
                    lim = bza_pkg::TOTAL_BITS;
                b = 0;
                while (b < lim && used_map[b])
                    b++;
                if (b >= lim) begin
                    r.status = bza_pkg::ST_NONE_FREE;
                end else begin
                    used_map[b] = 1'b1;
                    if (b == 0) begin
                        // Bit zero has no zone: keep it set, report range.
                        r.status = bza_pkg::ST_RANGE;
                    end else begin
                        r.zone_out = bza_pkg::ZONE_W'(b + cfg_fdz - 1);
                        if (free_cnt != 0)
                            free_cnt = free_cnt - 1'b1;
                    end
                end
                r.free_total = free_cnt;
            end
            bza_pkg::FUNC_FREE: begin
                zone_i = fz;
                cnt    = rl;
                clr    = 0;
                if (zone_i < cfg_fdz || zone_i + cnt >= cfg_zones) begin
                    r.status = bza_pkg::ST_RANGE;
                end else begin
                    // Walk the run block by block; check each block before clearing it,
                    // even for a zero-length run.
                    idx  = zone_i - cfg_fdz + 1;
                    stop = 1'b0;
                    while (!stop) begin
                        blk  = idx / bza_pkg::MAP_BLOCK_BITS;
                        left = bza_pkg::MAP_BLOCK_BITS - (idx % bza_pkg::MAP_BLOCK_BITS);
                        n    = (cnt < left) ? cnt : left;
                        if (blk >= nb) begin
                            r.status = bza_pkg::ST_NO_BLOCK;
                            stop     = 1'b1;
                        end else begin
                            for (k = 0; k < n; k++) begin
                                if (used_map[idx + k]) begin
                                    used_map[idx + k] = 1'b0;
                                    if (free_cnt != bza_pkg::CNT_MAX)
                                        free_cnt = free_cnt + 1'b1;
                                end else begin
                                    clr++;
                                end
                            end
                            idx += n;
                            cnt -= n;
                            if (cnt == 0)
                                stop = 1'b1;
                        end
                    end
                end
                r.free_total    = free_cnt;
                r.already_clear = bza_pkg::CNT_W'(clr);
            end
            bza_pkg::FUNC_COUNT: begin
                c = 0;
                for (k = 0; k < nb * bza_pkg::MAP_BLOCK_BITS; k++)
                    if (!used_map[k])
                        c++;
                r.free_total = bza_pkg::CNT_W'(c);
            end
            default: begin
                r.status     = bza_pkg::ST_RANGE;
                r.free_total = free_cnt;
            end
        endcase
        return r;
    endfunction

    // Idle length: mostly short, a few long, none in a no-idle stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            err_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, want_v, got_v);
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: offer queued transactions, hold valid and payload
    // until accepted, and predict each result at the accepting edge.
    // ------------------------------------------------------------------
    int send_gap = 0;

    always @(posedge i_clk) begin : req_driver
        t_zone_result pred;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && o_ready) begin
                pred = apply_zone_op(i_func, i_first_zone, i_run_length);
                zone_result_q.push_back(pred);
                void'(zone_op_q.pop_front());
            end
            if (i_valid && !o_ready) begin
                // hold the pending transaction
            end else if (send_gap > 0) begin
                i_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (zone_op_q.size() > 0) begin
                i_valid      <= 1'b1;
                i_func       <= zone_op_q[0].func;
                i_first_zone <= zone_op_q[0].first_zone;
                i_run_length <= zone_op_q[0].run_length;
                send_gap     <= pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each accepted result with the oldest
    // prediction; drive ready with random stalls and one long hold-off.
    // ------------------------------------------------------------------
    int  rx_gap    = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge i_clk) begin : result_monitor
        t_zone_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (zone_result_q.size() == 0) begin
                    err_count++;
                    $display("%0t: result with nothing expected: zone %0d status %0d",
                             $time, o_zone_out, o_status);
                end else begin
                    want = zone_result_q.pop_front();
                    check_field("zone_out", want.zone_out, o_zone_out);
                    check_field("status", want.status, o_status);
                    check_field("free_total", want.free_total, o_free_total);
                    check_field("already_clear", want.already_clear, o_already_clear);
                end
            end
            if (hold_left > 0) begin
                // Long hold-off: let the block fill up and stall its input.
                i_ready   <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (long_hold_req && !hold_done) begin
                i_ready   <= 1'b0;
                hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
            end else if (rx_gap > 0) begin
                i_ready <= 1'b0;
                rx_gap  <= rx_gap - 1;
            end else begin
                i_ready <= 1'b1;
                rx_gap  <= pick_gap();
            end
        end
    end

    // Abort a run that hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Write one register through the APB port: setup, then access.
    task automatic apb_write(input bza_pkg::t_reg_idx idx,
                             input logic [bza_pkg::DATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            bza_pkg::REG_FIRST_DATA_ZONE: cfg_fdz    = val[bza_pkg::ZONE_W-1:0];
            bza_pkg::REG_ZONE_COUNT:      cfg_zones  = val[bza_pkg::ZONE_W-1:0];
            bza_pkg::REG_MAP_BLOCKS:      cfg_blocks = val[bza_pkg::MBU_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int fdz, input int zones, input int blocks);
        apb_write(bza_pkg::REG_FIRST_DATA_ZONE, bza_pkg::DATA_W'(fdz));
        apb_write(bza_pkg::REG_ZONE_COUNT, bza_pkg::DATA_W'(zones));
        apb_write(bza_pkg::REG_MAP_BLOCKS, bza_pkg::DATA_W'(blocks));
    endtask

    // Wait until every queued request is accepted and every result is back.
    task automatic wait_idle();
        while (zone_op_q.size() != 0 || zone_result_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Queue random requests, mostly well formed for the current setting.
    task automatic push_random_ops(input int count);
        t_zone_op op;
        int r, q, span, fz_i, rl_i;
        for (int i = 0; i < count; i++) begin
            r             = $urandom_range(0, 99);
            op.first_zone = bza_pkg::ZONE_W'($urandom);
            op.run_length = bza_pkg::RUN_W'($urandom);
            if (r < 38) begin
                op.func = bza_pkg::FUNC_ALLOC;
            end else if (r < 80) begin
                // Free a run that mostly lands inside the data zones.
                op.func = bza_pkg::FUNC_FREE;
                span    = (cfg_zones > cfg_fdz) ? cfg_zones - cfg_fdz : 1;
                if (span > 4200)
                    span = 4200;
                fz_i = cfg_fdz + $urandom_range(0, span - 1);
                q    = $urandom_range(0, 99);
                if (q < 80)
                    rl_i = $urandom_range(0, 40);
                else if (q < 95)
                    rl_i = $urandom_range(0, 300);
                else
                    rl_i = $urandom_range(0, 4096);
                if ($urandom_range(0, 9) != 0 && fz_i < cfg_zones && fz_i + rl_i >= cfg_zones)
                    rl_i = cfg_zones - fz_i - 1;
                op.first_zone = bza_pkg::ZONE_W'(fz_i);
                op.run_length = bza_pkg::RUN_W'(rl_i);
            end else if (r < 90) begin
                op.func = bza_pkg::FUNC_COUNT;
            end else begin
                // Noise: any code, any field value.
                op.func = bza_pkg::FUNC_W'($urandom_range(0, 3));
            end
            zone_op_q.push_back(op);
        end
    endtask

    task automatic run_phase(input int fdz, input int zones, input int blocks,
                             input int count, input bit quiet, input bit hold);
        wait_idle();
        set_config(fdz, zones, blocks);
        no_idle = quiet;
        push_random_ops(count);
        if (hold)
            long_hold_req = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : test_seq
        t_zone_op d;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part: data zones start at 100, bit i is zone i + 99,
        // one map block in use so bits 1024 and up have no block.
        set_config(100, 1200, 1);
        d = '{bza_pkg::FUNC_COUNT, 16'd0, 13'd0};       zone_op_q.push_back(d); // none free
        d = '{bza_pkg::FUNC_ALLOC, 16'd0, 13'd0};       zone_op_q.push_back(d); // map full
        d = '{bza_pkg::FUNC_FREE, 16'd100, 13'd10};     zone_op_q.push_back(d);
        d = '{bza_pkg::FUNC_ALLOC, 16'hFFFF, 13'h1FFF}; zone_op_q.push_back(d); // zone 100
        d = '{bza_pkg::FUNC_FREE, 16'd100, 13'd5};      zone_op_q.push_back(d); // some clear
        d = '{bza_pkg::FUNC_FREE, 16'd99, 13'd1};       zone_op_q.push_back(d); // below data
        d = '{bza_pkg::FUNC_FREE, 16'd1190, 13'd10};    zone_op_q.push_back(d); // hits count
        d = '{bza_pkg::FUNC_FREE, 16'd0, 13'd0};        zone_op_q.push_back(d);
        d = '{bza_pkg::FUNC_FREE, 16'd100, 13'd4096};   zone_op_q.push_back(d);
        d = '{bza_pkg::FUNC_FREE, 16'd1189, 13'd10};    zone_op_q.push_back(d); // no block
        d = '{bza_pkg::FUNC_FREE, 16'd1119, 13'd8};     zone_op_q.push_back(d); // partial
        d = '{bza_pkg::FUNC_FREE, 16'd1123, 13'd0};     zone_op_q.push_back(d); // zero, missing
        d = '{bza_pkg::FUNC_FREE, 16'd1122, 13'd0};     zone_op_q.push_back(d); // zero, present
        d = '{bza_pkg::FUNC_COUNT, 16'hFFFF, 13'h1FFF}; zone_op_q.push_back(d);
        d = '{2'd3, 16'hFFFF, 13'h1FFF};                zone_op_q.push_back(d); // unknown op
        d = '{2'd3, 16'd0, 13'd0};                      zone_op_q.push_back(d);
        d = '{bza_pkg::FUNC_FREE, 16'd100, 13'd1099};   zone_op_q.push_back(d); // whole block
        d = '{bza_pkg::FUNC_ALLOC, 16'd0, 13'd0};       zone_op_q.push_back(d);
        d = '{bza_pkg::FUNC_ALLOC, 16'd0, 13'd0};       zone_op_q.push_back(d);
        d = '{bza_pkg::FUNC_ALLOC, 16'd0, 13'd0};       zone_op_q.push_back(d);
        d = '{bza_pkg::FUNC_COUNT, 16'd0, 13'd0};       zone_op_q.push_back(d);

        // Random part over several settings, extremes among them.
        run_phase(100, 1200, 1, 250, 1'b0, 1'b0);
        run_phase(0, 65535, 7, 250, 1'b0, 1'b1);   // too many blocks; long hold-off
        run_phase(65535, 65535, 4, 60, 1'b0, 1'b0); // empty search range
        run_phase(2, 4100, 4, 300, 1'b1, 1'b0);    // limit capped by map size, no idling
        run_phase(10, 2000, 0, 60, 1'b0, 1'b0);    // no map block in use
        run_phase(30, 730, 2, 300, 1'b0, 1'b0);
        run_phase(5000, 1000, 5, 40, 1'b0, 1'b0);  // zone_count below first data zone
        run_phase(1, 3000, 3, 260, 1'b0, 1'b0);

        // Drain, then allow for a stray late result.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/bza_pkg.sv
rtl/bitmap_zone_allocator.sv
sim/tb_top.sv
